// ===== rtl/core/fal_pkg.sv =====
package fal_pkg;

   // pool size default, handed to the top level parameter
   localparam int ENTRIES_DEFAULT = 64;

   // fixed field widths of the request and response ports
   localparam int CMD_W   = 1;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic init_wr;   // write one link of the reset chain
      logic capture;   // latch an accepted request
      logic exec;      // carry out the latched request
   } fal_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic init_last; // the last link of the reset chain is being written
   } fal_status_type;

endpackage

// ===== rtl/core/fal_ctrl.sv =====
module fal_ctrl
   import fal_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  fal_status_type status,
   output logic           busy,
   output fal_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   // commands to the datapath
   assign cmd.init_wr = (state_ff == ST_INIT);
   assign cmd.capture = (state_ff == ST_IDLE) && start && !busy_ff;
   assign cmd.exec    = (state_ff == ST_EXEC);

   assign busy = busy_ff;

endmodule

// ===== rtl/core/fal_dpath.sv =====
module fal_dpath
   import fal_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  fal_cmd_type        cmd,
   output fal_status_type     status,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [INDEX_W-1:0] req_entry_index,
   output logic               rsp_valid,
   output logic               rsp_granted,
   output logic [INDEX_W-1:0] rsp_alloc_index,
   output logic [COUNT_W-1:0] rsp_free_count
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LINK_W = $clog2(ENTRIES + 1);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   localparam logic [LINK_W-1:0] NULL_LINK   = LINK_W'(ENTRIES);
   localparam logic [CNT_W-1:0]  FULL_COUNT  = CNT_W'(ENTRIES);
   localparam logic [IDX_W-1:0]  LAST_ENTRY  = IDX_W'(ENTRIES - 1);

   // link store and its registered read port
   logic [LINK_W-1:0] link_mem [ENTRIES];
   logic [LINK_W-1:0] rd_link_ff;
   logic [IDX_W-1:0]  rd_addr;

   // list state
   logic [LINK_W-1:0] head_ff;
   logic [LINK_W-1:0] head_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [IDX_W-1:0]  init_ff;

   // latched request
   logic [CMD_W-1:0]   cmd_ff;
   logic [INDEX_W-1:0] idx_ff;

   // response registers
   logic               rsp_valid_ff;
   logic               granted_ff;
   logic               granted_in;
   logic [INDEX_W-1:0] alloc_ff;
   logic [INDEX_W-1:0] alloc_in;

   // write port
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [LINK_W-1:0] wr_data;

   logic head_valid;
   logic idx_valid;

   assign head_valid = (head_ff < NULL_LINK);
   assign idx_valid  = ({{(32 - INDEX_W){1'b0}}, idx_ff} < 32'(ENTRIES));
   assign rd_addr    = head_valid ? head_ff[IDX_W-1:0] : '0;

   assign status.init_last = cmd.init_wr && (init_ff == LAST_ENTRY);

   // write port select and next list state
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = init_ff;
      wr_data    = LINK_W'(init_ff) + LINK_W'(1);
      head_in    = head_ff;
      count_in   = count_ff;
      granted_in = 1'b0;
      alloc_in   = '0;
      if (cmd.init_wr) begin
         wr_en = 1'b1;
      end else if (cmd.exec) begin
         if (cmd_ff == CMD_ALLOC) begin
            if (head_valid) begin
               // pop the head, its link goes null
               wr_en      = 1'b1;
               wr_addr    = rd_addr;
               wr_data    = NULL_LINK;
               head_in    = rd_link_ff;
               granted_in = 1'b1;
               alloc_in   = INDEX_W'(head_ff);
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end else begin
            if (idx_valid) begin
               // push the freed entry at the head
               wr_en      = 1'b1;
               wr_addr    = IDX_W'(idx_ff);
               wr_data    = head_ff;
               head_in    = LINK_W'(idx_ff);
               granted_in = 1'b1;
               if (count_ff < FULL_COUNT) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   // link store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      rd_link_ff <= link_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= FULL_COUNT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.exec;
         if (cmd.init_wr && !status.init_last) begin
            init_ff <= init_ff + IDX_W'(1);
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         idx_ff <= req_entry_index;
      end
      if (cmd.exec) begin
         granted_ff <= granted_in;
         alloc_ff   <= alloc_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = granted_ff;
   assign rsp_alloc_index = alloc_ff;
   assign rsp_free_count  = COUNT_W'(count_ff);

endmodule

// ===== rtl/core/free_list_entry_allocator_unit.sv =====
// Free list allocator for a pool of ENTRIES entries, kept as a LIFO list
// threaded through a link memory.
// Request channel: drive req_cmd (0 allocate, 1 free) and req_entry_index
// with start; the request is taken at a clock edge where start is high and
// busy is low. The entry index is used only on free.
// Response channel: rsp_valid is high for exactly one cycle with
// rsp_granted, rsp_alloc_index and rsp_free_count; the receiver cannot
// stall, so the response must be taken in that cycle.
// Sequence: an accept moves the controller to its execute state and the
// response is registered from that state. Busy is high in the cycle after
// an accept, so no new request is taken before the last one has executed;
// the head entry's link memory read is registered before the pop uses it.
// Reset: synchronous, active high. Afterwards the block writes the reset
// chain (entry i links to i+1) into every link memory entry with busy
// high; requests are taken once busy falls.
// Free requests are not checked against the allocated set; an index at or
// above ENTRIES is refused.
module free_list_entry_allocator_unit
   import fal_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [INDEX_W-1:0] req_entry_index,
   output logic               rsp_valid,
   output logic               rsp_granted,
   output logic [INDEX_W-1:0] rsp_alloc_index,
   output logic [COUNT_W-1:0] rsp_free_count
);

   fal_cmd_type    cmd;
   fal_status_type status;

   // sequencing
   fal_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // list state and link memory
   fal_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_granted     (rsp_granted),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_free_count  (rsp_free_count)
   );

endmodule
